// ===== design/ogru_pkg.sv =====
// Shared types, constants and helpers for the occupancy grid ray update block.
// No dependencies; imported by the controller, the datapath and the top level.
package ogru_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int COORD_W    = 11;
  localparam int RD_W       = 9;
  localparam int VAL_W      = 7;
  localparam int FREED_W    = 10;
  localparam int DIM_W      = 10;
  localparam int FINC_W     = 8;
  localparam int HINC_W     = 7;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [VAL_W-1:0] CELL_UNKNOWN = 7'd50;
  localparam logic [VAL_W-1:0] CELL_MAX     = 7'd100;

  localparam logic OP_RAY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_APPLIED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT_OUT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ROBOT_OUT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_INC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_INC    = 2'd3;

  localparam logic [DIM_W-1:0]         RST_MAP_WIDTH  = 10'd512;
  localparam logic [DIM_W-1:0]         RST_MAP_HEIGHT = 10'd512;
  localparam logic signed [FINC_W-1:0] RST_FREE_INC   = -8'sd1;
  localparam logic [HINC_W-1:0]        RST_HIT_INC    = 7'd2;

  typedef struct packed {
    logic load_item;
    logic clear;
    logic setup_steep;
    logic setup_order;
    logic setup_delta;
    logic walk;
    logic hit_rd;
    logic hit_wr;
    logic read_rd;
    logic read_cap;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic hit_in;
    logic robot_in;
    logic walk_last;
    logic clear_last;
  } sts_t;

  function automatic logic [VAL_W-1:0] clamp_val(input logic signed [VAL_W+1:0] v);
    logic [VAL_W-1:0] r;
    if (v < 9'sd0) begin
      r = '0;
    end else if (v > $signed({2'b00, CELL_MAX})) begin
      r = CELL_MAX;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ogru_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ogru_ctrl.sv =====
// Sequencing state machine: clearing pass, ray walk and cell read.
// Depends on ogru_pkg; drives the datapath through cmd_t, watches sts_t.
module ogru_ctrl import ogru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_STEEP,
    S_ORDER,
    S_DELTA,
    S_WALK,
    S_HIT_RD,
    S_HIT_WR,
    S_READ_RD,
    S_READ_CAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    cmd.load_item   = in_valid && (state == S_IDLE);
    cmd.load_out    = (state == S_DONE) && (!out_valid || out_ready);
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.op_read) state_next = S_READ_RD;
        else if (sts.hit_in && sts.robot_in) state_next = S_STEEP;
        else state_next = S_DONE;
      end
      S_STEEP: begin
        cmd.setup_steep = 1'b1;
        state_next      = S_ORDER;
      end
      S_ORDER: begin
        cmd.setup_order = 1'b1;
        state_next      = S_DELTA;
      end
      S_DELTA: begin
        cmd.setup_delta = 1'b1;
        state_next      = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_next = S_HIT_RD;
      end
      S_HIT_RD: begin
        cmd.hit_rd = 1'b1;
        state_next = S_HIT_WR;
      end
      S_HIT_WR: begin
        cmd.hit_wr = 1'b1;
        state_next = S_DONE;
      end
      S_READ_RD: begin
        cmd.read_rd = 1'b1;
        state_next  = S_READ_CAP;
      end
      S_READ_CAP: begin
        cmd.read_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ogru_dp.sv =====
// Datapath: configuration registers, item latch, line stepper, map RAM and result.
// Depends on ogru_pkg and ogru_ram; steered by cmd_t from ogru_ctrl.
module ogru_dp import ogru_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         cfg_wr,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         op,
  input  logic signed [COORD_W-1:0]    robot_x,
  input  logic signed [COORD_W-1:0]    robot_y,
  input  logic signed [COORD_W-1:0]    hit_x,
  input  logic signed [COORD_W-1:0]    hit_y,
  input  logic [RD_W-1:0]              read_x,
  input  logic [RD_W-1:0]              read_y,
  output logic [STATUS_W-1:0]          status,
  output logic [VAL_W-1:0]             cell_value,
  output logic                         cell_unknown,
  output logic [FREED_W-1:0]           cells_freed
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = COORD_W + 1;
  localparam int EW    = COORD_W + 2;

  logic [DIM_W-1:0]         map_width;
  logic [DIM_W-1:0]         map_height;
  logic signed [FINC_W-1:0] free_inc;
  logic [HINC_W-1:0]        hit_inc;

  logic                      it_op;
  logic signed [COORD_W-1:0] rx, ry, hx, hy;
  logic [RD_W-1:0]           rdx, rdy;

  logic                 steep;
  logic signed [WW-1:0] wx, wy, wx_end, wy_end, dx, dy;
  logic                 ystep_neg;
  logic signed [EW-1:0] err;
  logic                 pend_valid;
  logic [AW-1:0]        pend_addr;
  logic [FREED_W-1:0]   freed;
  logic [VAL_W-1:0]     res_val;
  logic [AW-1:0]        clr_cnt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VAL_W-1:0]     ram_wdata, ram_rdata;

  logic                 hit_in, robot_in, rd_in;
  logic signed [WW-1:0] px, py;
  logic                 excl;
  logic signed [EW-1:0] err_t;
  logic signed [EW:0]   err2;
  logic [AW-1:0]        hit_addr, walk_addr, rd_addr;
  logic [VAL_W-1:0]     free_val, hit_val;

  function automatic logic x_inside(input logic signed [COORD_W-1:0] c);
    return !c[COORD_W-1] && (int'(c[COORD_W-2:0]) < int'(map_width))
           && (int'(c[COORD_W-2:0]) < MAX_WIDTH);
  endfunction

  function automatic logic y_inside(input logic signed [COORD_W-1:0] c);
    return !c[COORD_W-1] && (int'(c[COORD_W-2:0]) < int'(map_height))
           && (int'(c[COORD_W-2:0]) < MAX_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-2:0] x,
                                              input logic [COORD_W-2:0] y);
    return AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  function automatic logic signed [WW-1:0] abs_w(input logic signed [WW-1:0] v);
    return v[WW-1] ? -v : v;
  endfunction

  assign hit_in   = x_inside(hx) && y_inside(hy);
  assign robot_in = x_inside(rx) && y_inside(ry);
  assign rd_in    = (int'(rdx) < int'(map_width)) && (int'(rdx) < MAX_WIDTH)
                    && (int'(rdy) < int'(map_height)) && (int'(rdy) < MAX_HEIGHT);

  assign px   = steep ? wy : wx;
  assign py   = steep ? wx : wy;
  assign excl = (px == WW'(hx)) && (py == WW'(hy));

  assign err_t = err + EW'(dy);
  assign err2  = {err_t, 1'b0};

  assign hit_addr  = cell_addr(hx[COORD_W-2:0], hy[COORD_W-2:0]);
  assign walk_addr = cell_addr(px[COORD_W-2:0], py[COORD_W-2:0]);
  assign rd_addr   = cell_addr({1'b0, rdx}, {1'b0, rdy});

  assign free_val = clamp_val($signed({2'b00, ram_rdata}) + (VAL_W+2)'(free_inc));
  assign hit_val  = clamp_val($signed({2'b00, ram_rdata}) + $signed({2'b00, hit_inc}));

  assign sts.op_read    = (it_op == OP_READ);
  assign sts.hit_in     = hit_in;
  assign sts.robot_in   = robot_in;
  assign sts.walk_last  = (wx == wx_end);
  assign sts.clear_last = (clr_cnt == AW'(DEPTH - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = free_val;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = CELL_UNKNOWN;
    end else if (cmd.hit_wr) begin
      ram_we    = 1'b1;
      ram_waddr = hit_addr;
      ram_wdata = hit_val;
    end else if ((cmd.walk || cmd.hit_rd) && pend_valid) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_addr;
    if (cmd.walk) begin
      ram_re    = !excl;
      ram_raddr = walk_addr;
    end else if (cmd.hit_rd) begin
      ram_re    = 1'b1;
      ram_raddr = hit_addr;
    end else if (cmd.read_rd) begin
      ram_re = rd_in;
    end
  end

  ogru_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= RST_MAP_WIDTH;
      map_height <= RST_MAP_HEIGHT;
      free_inc   <= RST_FREE_INC;
      hit_inc    <= RST_HIT_INC;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_MAP_WIDTH:  map_width  <= cfg_data[DIM_W-1:0];
          REG_MAP_HEIGHT: map_height <= cfg_data[DIM_W-1:0];
          REG_FREE_INC:   free_inc   <= cfg_data[FINC_W-1:0];
          REG_HIT_INC:    hit_inc    <= cfg_data[HINC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      pend_valid <= cmd.walk && !excl;
    end
  end

  // Item, stepper and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_op   <= op;
      rx      <= robot_x;
      ry      <= robot_y;
      hx      <= hit_x;
      hy      <= hit_y;
      rdx     <= read_x;
      rdy     <= read_y;
      freed   <= '0;
      res_val <= '0;
    end
    if (cmd.setup_steep) begin
      steep <= abs_w(WW'(hy) - WW'(ry)) > abs_w(WW'(hx) - WW'(rx));
    end
    if (cmd.setup_order) begin
      if ((steep ? ry : rx) > (steep ? hy : hx)) begin
        wx     <= WW'(steep ? hy : hx);
        wy     <= WW'(steep ? hx : hy);
        wx_end <= WW'(steep ? ry : rx);
        wy_end <= WW'(steep ? rx : ry);
      end else begin
        wx     <= WW'(steep ? ry : rx);
        wy     <= WW'(steep ? rx : ry);
        wx_end <= WW'(steep ? hy : hx);
        wy_end <= WW'(steep ? hx : hy);
      end
    end
    if (cmd.setup_delta) begin
      dx        <= wx_end - wx;
      dy        <= abs_w(wy_end - wy);
      ystep_neg <= !(wy < wy_end);
      err       <= '0;
    end
    if (cmd.walk) begin
      wx        <= wx + 1'b1;
      pend_addr <= walk_addr;
      if (err2 >= (EW+1)'(dx)) begin
        wy  <= ystep_neg ? wy - 1'b1 : wy + 1'b1;
        err <= err_t - EW'(dx);
      end else begin
        err <= err_t;
      end
    end
    if ((cmd.walk || cmd.hit_rd) && pend_valid) begin
      freed <= freed + 1'b1;
    end
    if (cmd.hit_wr) begin
      res_val <= hit_val;
    end
    if (cmd.read_cap) begin
      res_val <= rd_in ? ram_rdata : CELL_UNKNOWN;
    end
    if (cmd.load_out) begin
      if (it_op == OP_READ) status <= ST_READ;
      else if (!hit_in) status <= ST_HIT_OUT;
      else if (!robot_in) status <= ST_ROBOT_OUT;
      else status <= ST_APPLIED;
      cell_value   <= res_val;
      cell_unknown <= (res_val == CELL_UNKNOWN);
      cells_freed  <= freed;
    end
  end

endmodule

// ===== design/occupancy_grid_ray_update.sv =====
// Occupancy grid ray update, top level. An applied ray does one map read-modify-write
// per cell on the line, overlapped in the one-read one-write map RAM.
// One item at a time; the next is taken once the previous result is registered.
// After reset a clearing pass writes 50 to all MAX_WIDTH * MAX_HEIGHT cells, one a
// cycle; no item is taken meanwhile, config writes are.
module occupancy_grid_ray_update import ogru_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [COORD_W-1:0] robot_x,
  input  logic signed [COORD_W-1:0] robot_y,
  input  logic signed [COORD_W-1:0] hit_x,
  input  logic signed [COORD_W-1:0] hit_y,
  input  logic [RD_W-1:0]           read_x,
  input  logic [RD_W-1:0]           read_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [VAL_W-1:0]          cell_value,
  output logic                      cell_unknown,
  output logic [FREED_W-1:0]        cells_freed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ogru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ogru_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .robot_x      (robot_x),
    .robot_y      (robot_y),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .read_x       (read_x),
    .read_y       (read_y),
    .status       (status),
    .cell_value   (cell_value),
    .cell_unknown (cell_unknown),
    .cells_freed  (cells_freed)
  );

`ifndef SYNTHESIS
  // one map RAM access source per cycle
  a_ram_owner: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.walk, cmd.hit_rd, cmd.hit_wr, cmd.read_rd}))
    else $error("map RAM driven by more than one operation");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_HIT_OUT || status == ST_ROBOT_OUT)
      |-> cell_value == '0 && cells_freed == '0)
    else $error("skipped ray carries data");

  a_read_freed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_READ |-> cells_freed == '0)
    else $error("read result reports freed cells");
`endif

endmodule
